// ===== hw/rtl/sbs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbs_pkg: shared types and constants of the subgroup barrier scheduler
// Opcodes, counter limits, register addresses and the control bundle that
// the sequencer sends down the row of subgroup cells.
// ----------------------------------------------------------------------------
package sbs_pkg;

    localparam logic [1:0] OP_GROUP_ARRIVE = 2'd0;
    localparam logic [1:0] OP_SUB_ARRIVE   = 2'd1;
    localparam logic [1:0] OP_SCHEDULE     = 2'd2;
    localparam logic [1:0] OP_START        = 2'd3;

    localparam logic [10:0] CNT_MAX = 11'd2047;
    localparam logic [4:0]  ACT_MAX = 5'd31;

    localparam logic [1:0] REG_SIZE_X = 2'd0;
    localparam logic [1:0] REG_SIZE_Y = 2'd1;
    localparam logic [1:0] REG_SIZE_Z = 2'd2;
    localparam logic [1:0] REG_WIDTH  = 2'd3;

    // command travelling down the cell row, one cell per cycle
    typedef struct packed {
        logic        clear;     // start: drop all counts and marks
        logic        wipe;      // group barrier done: clear counts
        logic        retire;    // release full marked subgroups
        logic        arrive;    // count an arrival in the target cell
        logic        sub;       // arrival is a subgroup barrier arrival
    } cell_cmd_t;

endpackage

// ===== hw/rtl/sbs_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbs_cell: one subgroup slot of the scheduler row
// Holds arrival count and barrier mark of one subgroup; acts when the
// command token passes its position; a clear acts on every cell.
// ----------------------------------------------------------------------------
module sbs_cell
    import sbs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        hit,        // token is at this cell
    input  cell_cmd_t   cmd,
    input  logic        target,     // this cell is the arrival subgroup
    input  logic        in_range,   // index below subgroup_total
    input  logic [10:0] width,
    output logic        full,
    output logic [10:0] count,
    output logic        rel_fire,   // this cell is released now
    output logic        new_mark    // this arrival opens a new barrier
);

    logic [10:0] count_reg, count_next;
    logic        mark_reg, mark_next;

    assign count    = count_reg;
    assign full     = count_reg >= width;
    assign rel_fire = hit && cmd.retire && in_range && mark_reg && (count_reg == width);
    assign new_mark = hit && cmd.arrive && target && cmd.sub
                      && (count_reg == 11'd0) && !mark_reg;

    always_comb
    begin
        count_next = count_reg;
        mark_next  = mark_reg;
        if (cmd.clear)
        begin
            count_next = '0;
            mark_next  = 1'b0;
        end
        else if (hit)
        begin
            if (cmd.wipe && in_range)
                count_next = '0;
            if (rel_fire)
            begin
                count_next = '0;
                mark_next  = 1'b0;
            end
            if (cmd.arrive && target)
            begin
                if (new_mark)
                    mark_next = 1'b1;
                if (count_reg != CNT_MAX)
                    count_next = count_reg + 11'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            mark_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            mark_reg  <= mark_next;
        end
    end

endmodule

// ===== hw/rtl/sbs_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbs_divider: restoring divider, one quotient bit per cycle
// Divides a 22-bit dividend by an 11-bit divisor.
// ----------------------------------------------------------------------------
module sbs_divider
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  logic [21:0] dividend,
    input  logic [10:0] divisor,
    output logic        done,
    output logic [21:0] quotient
);

    logic [21:0] quo_reg, quo_next;
    logic [11:0] rem_reg, rem_next;
    logic [10:0] dsr_reg, dsr_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [11:0] trial;

    assign quotient = quo_reg;
    assign done     = done_reg;
    assign trial    = {rem_reg[10:0], quo_reg[21]};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (go)
        begin
            quo_next = dividend;
            rem_next = '0;
            dsr_next = divisor;
            cnt_next = 5'd21;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = trial - {1'b0, dsr_reg};
                quo_next = {quo_reg[20:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[20:0], 1'b0};
            end
            if (cnt_reg == 5'd0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
            else
                cnt_next = cnt_reg - 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

endmodule

// ===== hw/rtl/subgroup_barrier_scheduler_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// subgroup_barrier_scheduler_top: barrier tracking for one work-group
// Counts arrivals per subgroup, resolves barriers and picks the next item.
// ----------------------------------------------------------------------------
// Usage: drive opcode and item ids with start while busy is low. Start and
// arrival commands first run the id multiplies and the serial divider, which
// keep busy high; a start ends there, an arrival then walks the cell row one
// cell per cycle. A schedule request walks the row twice (resolve, then a
// scan that stops at the first subgroup below subgroup_total that is not
// full, or at the last cell) and then shows next_item with done.
// next_item is shown for exactly one cycle with done high and cannot be
// stalled, so the receiver must take it when it appears. Registers may be
// written only while busy is low.
// ----------------------------------------------------------------------------
module subgroup_barrier_scheduler_top
    import sbs_pkg::*;
#(
    parameter int MAX_SUBGROUPS   = 16,
    parameter int MAX_GROUP_ITEMS = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  opcode,
    input  logic [9:0]  item_x,
    input  logic [9:0]  item_y,
    input  logic [9:0]  item_z,
    output logic        done,
    output logic [9:0]  next_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IW = $clog2(MAX_SUBGROUPS);
    localparam int SW = (IW < 1) ? 1 : IW;
    localparam int NW = $clog2(MAX_SUBGROUPS + 1);

    // sequencer states
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MUL1  = 4'd1;
    localparam logic [3:0] ST_MUL2  = 4'd2;
    localparam logic [3:0] ST_DIV   = 4'd3;
    localparam logic [3:0] ST_WAIT  = 4'd4;
    localparam logic [3:0] ST_WALK  = 4'd5;
    localparam logic [3:0] ST_SCAN  = 4'd6;
    localparam logic [3:0] ST_OUT   = 4'd7;
    localparam logic [3:0] ST_PREP  = 4'd8;

    logic [10:0] sx_reg, sy_reg, sz_reg, sw_reg;
    logic [10:0] width;
    assign width = (sw_reg == 11'd0) ? 11'd1 : sw_reg;

    assign pready = 1'b1;
    always_comb
    begin
        case (paddr[3:2])
            REG_SIZE_X: prdata = {21'd0, sx_reg};
            REG_SIZE_Y: prdata = {21'd0, sy_reg};
            REG_SIZE_Z: prdata = {21'd0, sz_reg};
            REG_WIDTH:  prdata = {21'd0, sw_reg};
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sx_reg <= 11'd1;
            sy_reg <= 11'd1;
            sz_reg <= 11'd1;
            sw_reg <= 11'd1;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[3:2])
                REG_SIZE_X: sx_reg <= pwdata[10:0];
                REG_SIZE_Y: sy_reg <= pwdata[10:0];
                REG_SIZE_Z: sz_reg <= pwdata[10:0];
                REG_WIDTH:  sw_reg <= pwdata[10:0];
                default:    sx_reg <= sx_reg;
            endcase
        end
    end

    // sequencer registers
    logic [3:0]  state_reg, state_next;
    logic [1:0]  op_reg;
    logic [9:0]  x_reg, y_reg, z_reg;
    logic [21:0] p1_reg, lin_reg;   // products, capped where safe
    logic [SW-1:0] pos_reg, pos_next;
    logic [SW-1:0] sg_reg;
    logic        sg_ok_reg;
    logic [NW-1:0] total_reg;
    logic [10:0] waiting_reg;
    logic [4:0]  active_reg;
    logic        release_mode_reg;
    logic        wipe_mode_reg;
    logic [9:0]  result_reg;
    logic        done_reg;

    logic        div_go, div_done;
    logic [21:0] div_a, quotient;

    sbs_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (div_go),
        .dividend (div_a),
        .divisor  (width),
        .done     (div_done),
        .quotient (quotient)
    );

    // product pipeline: sx*sy (22 bits), then lin = z*(sx*sy) + y*sx + x.
    // For ids, sx*sy <= 2^22; z*that may be wide; cap lin at 2^22-1, since
    // any value that large is out of range (total*width < 2^15).
    logic [32:0] zprod;
    logic [21:0] yprod;
    logic [33:0] lin_full;
    assign zprod    = {23'd0, z_reg} * {11'd0, p1_reg};
    assign yprod    = {12'd0, y_reg} * {11'd0, sx_reg};
    assign lin_full = {1'b0, zprod} + {12'd0, yprod} + {24'd0, x_reg};

    // start count: min(sx*sy*sz, MAX_GROUP_ITEMS)
    logic [32:0] items_full;
    logic [21:0] items_cap;
    assign items_full = {22'd0, sz_reg} * {11'd0, p1_reg};
    assign items_cap  = (items_full > 33'(MAX_GROUP_ITEMS)) ? 22'(MAX_GROUP_ITEMS)
                                                           : items_full[21:0];

    assign div_a  = (op_reg == OP_START) ? items_cap : lin_reg;

    // cell row
    cell_cmd_t   cmd;
    logic [MAX_SUBGROUPS-1:0] full_v, rel_v, mark_v;
    logic [10:0] count_v [MAX_SUBGROUPS];

    genvar g;
    generate
        for (g = 0; g < MAX_SUBGROUPS; g++)
        begin : g_cell
            sbs_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .hit      (pos_reg == SW'(g)),
                .cmd      (cmd),
                .target   (sg_reg == SW'(g)),
                .in_range (NW'(g) < total_reg),
                .width    (width),
                .full     (full_v[g]),
                .count    (count_v[g]),
                .rel_fire (rel_v[g]),
                .new_mark (mark_v[g])
            );
        end
    endgenerate

    logic        last_pos;
    logic        scan_hit;
    assign last_pos = (pos_reg == SW'(MAX_SUBGROUPS - 1));
    assign scan_hit = (NW'(pos_reg) < total_reg) && !full_v[pos_reg];

    always_comb
    begin
        cmd         = '0;
        cmd.clear   = (state_reg == ST_WAIT) && div_done && (op_reg == OP_START);
        cmd.wipe    = (state_reg == ST_WALK) && (op_reg == OP_SCHEDULE) && wipe_mode_reg;
        cmd.retire  = (state_reg == ST_WALK) && (op_reg == OP_SCHEDULE) && release_mode_reg;
        cmd.arrive  = (state_reg == ST_WALK) && (op_reg != OP_SCHEDULE) && sg_ok_reg;
        cmd.sub     = (op_reg == OP_SUB_ARRIVE);
    end

    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign next_item = result_reg;

    logic [21:0] need;   // width * subgroup_total, narrow enough here
    assign need = {11'd0, width} * {{(22-NW){1'b0}}, total_reg};

    logic [21:0] pick;
    assign pick = {{(22-SW){1'b0}}, pos_reg} * {11'd0, width}
                  + {11'd0, count_v[pos_reg]};

    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        div_go     = 1'b0;
        case (state_reg)
            ST_IDLE:
                if (start)
                    state_next = (opcode == OP_SCHEDULE) ? ST_PREP : ST_MUL1;
            ST_MUL1: state_next = ST_MUL2;
            ST_MUL2: state_next = ST_DIV;
            ST_DIV:
            begin
                div_go     = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT:
                if (div_done)
                begin
                    pos_next   = '0;
                    state_next = (op_reg == OP_START) ? ST_IDLE : ST_WALK;
                end
            ST_PREP:
            begin
                pos_next   = '0;
                state_next = ST_WALK;
            end
            ST_WALK:
                if (last_pos)
                begin
                    pos_next   = '0;
                    state_next = (op_reg == OP_SCHEDULE) ? ST_SCAN : ST_IDLE;
                end
                else
                    pos_next = pos_reg + SW'(1);
            ST_SCAN:
                if (scan_hit || last_pos)
                    state_next = ST_OUT;
                else
                    pos_next = pos_reg + SW'(1);
            ST_OUT: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            pos_reg          <= '0;
            total_reg        <= '0;
            waiting_reg      <= '0;
            active_reg       <= '0;
            done_reg         <= 1'b0;
            release_mode_reg <= 1'b0;
            wipe_mode_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            done_reg  <= 1'b0;
            // resolve decision, taken before the walk
            if (state_reg == ST_PREP)
            begin
                release_mode_reg <= (active_reg != 5'd0);
                wipe_mode_reg    <= (active_reg == 5'd0)
                                    && ({11'd0, waiting_reg} == need);
                if ((active_reg == 5'd0) && ({11'd0, waiting_reg} == need))
                    waiting_reg <= '0;
            end
            if (cmd.clear)
            begin
                waiting_reg <= '0;
                active_reg  <= '0;
                total_reg   <= (quotient > 22'(MAX_SUBGROUPS)) ? NW'(MAX_SUBGROUPS)
                                                               : quotient[NW-1:0];
            end
            if (|rel_v)
            begin
                waiting_reg <= (waiting_reg >= width) ? waiting_reg - width : 11'd0;
                if (active_reg != 5'd0)
                    active_reg <= active_reg - 5'd1;
            end
            if (cmd.arrive && (pos_reg == sg_reg))
            begin
                if (waiting_reg != CNT_MAX)
                    waiting_reg <= waiting_reg + 11'd1;
                if ((|mark_v) && (active_reg != ACT_MAX))
                    active_reg <= active_reg + 5'd1;
            end
            if (state_reg == ST_OUT)
                done_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && start)
        begin
            op_reg <= opcode;
            x_reg  <= item_x;
            y_reg  <= item_y;
            z_reg  <= item_z;
        end
        if (state_reg == ST_MUL1)
            p1_reg <= {11'd0, sx_reg} * {11'd0, sy_reg};
        if (state_reg == ST_MUL2)
            lin_reg <= (lin_full > 34'h3FFFFF) ? 22'h3FFFFF : lin_full[21:0];
        if ((state_reg == ST_WAIT) && div_done)
        begin
            sg_ok_reg <= ({{(22-NW){1'b0}}, total_reg} > quotient);
            sg_reg    <= quotient[SW-1:0];
        end
        if (state_reg == ST_SCAN)
            result_reg <= scan_hit ? pick[9:0] : 10'd0;
    end

    // a result appears only at the end of a scan
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg) == ST_OUT)
        else $error("result without scan");
    // busy stays high while the row walk runs
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> busy)
        else $error("walk while idle");
    // at most one cell releases per cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(rel_v))
        else $error("multiple releases");

endmodule
